// File: rtl/core/rwha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring wave height accumulator package
// Map geometry, fixed-point constants, controller states, datapath operations
// and the constant-divisor helper used by the exponential recurrence.
// ----------------------------------------------------------------------------
package rwha_pkg;

    localparam int unsigned MAP_WIDTH  = 64;
    localparam int unsigned MAP_HEIGHT = 64;
    localparam int unsigned MAP_SIZE   = MAP_WIDTH * MAP_HEIGHT;
    localparam int unsigned ADDR_W     = $clog2(MAP_SIZE);
    localparam int unsigned X_W        = $clog2(MAP_WIDTH);
    localparam int unsigned Y_W        = $clog2(MAP_HEIGHT);
    localparam int unsigned RU_W       = X_W + 1;
    localparam int unsigned RV_W       = Y_W + 1;

    localparam int unsigned ONE_Q16    = 65536;
    localparam int unsigned FULL_SCALE = 32768;
    localparam int unsigned SIN_A      = 102944;
    localparam int unsigned SIN_B      = 42047;
    localparam int unsigned SIN_C      = 4640;
    localparam int unsigned LOG2E_Q16  = 94548;
    localparam int unsigned LN2_Q16    = 45426;

    // Texel coordinate steps: u(x) = round(x * 65536 / (MAP_WIDTH - 1)).
    localparam int unsigned U_STEP_Q = ONE_Q16 / (MAP_WIDTH - 1);
    localparam int unsigned U_STEP_R = ONE_Q16 % (MAP_WIDTH - 1);
    localparam int unsigned U_R0     = (MAP_WIDTH - 1) / 2;
    localparam int unsigned V_STEP_Q = ONE_Q16 / (MAP_HEIGHT - 1);
    localparam int unsigned V_STEP_R = ONE_Q16 % (MAP_HEIGHT - 1);
    localparam int unsigned V_R0     = (MAP_HEIGHT - 1) / 2;

    localparam int unsigned SQRT_STEPS = 17;
    localparam int unsigned CNT_W      = $clog2(SQRT_STEPS);
    localparam int unsigned EXP_TERMS  = 5;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_RD_OUT, ST_DU, ST_SQ1, ST_SQ2, ST_SQRT,
        ST_PH, ST_X2, ST_IN, ST_PO, ST_MG, ST_S, ST_SS, ST_S3, ST_EM, ST_ED,
        ST_AT, ST_TERM, ST_WR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_RD, OP_RDOUT, OP_DU, OP_SQ1, OP_SQ2,
        OP_SQRT, OP_PH, OP_X2, OP_IN, OP_PO, OP_MG, OP_S, OP_SS, OP_S3,
        OP_EM, OP_ED, OP_AT, OP_TERM, OP_WR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic last_texel;
    } t_dp_sts;

    // Division by a small constant through reciprocal multiplication; exact
    // for every 16-bit dividend.
    function automatic logic [15:0] div_k(input logic [15:0] v, input logic [2:0] k);
        logic [31:0] m3;
        logic [33:0] m5;
        m3 = 32'(v) * 32'd43691;
        m5 = 34'(v) * 34'd52429;
        case (k)
            3'd1:    div_k = v;
            3'd2:    div_k = v >> 1;
            3'd3:    div_k = 16'(m3[31:17]);
            3'd4:    div_k = v >> 2;
            3'd5:    div_k = m5[33:18];
            default: div_k = v;
        endcase
    endfunction

endpackage

// File: rtl/core/rwha_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one apply or read request.
// ----------------------------------------------------------------------------
interface rwha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] texel_index;
    logic [15:0] center_u;
    logic [15:0] center_v;
    logic [15:0] ring_frequency;
    logic [15:0] decay_rate;
    logic [31:0] phase_time;

    modport source (output valid, command, texel_index, center_u, center_v,
                    ring_frequency, decay_rate, phase_time, input ready);
    modport sink   (input valid, command, texel_index, center_u, center_v,
                    ring_frequency, decay_rate, phase_time, output ready);
endinterface

// File: rtl/core/rwha_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one texel height read back from the map.
// ----------------------------------------------------------------------------
interface rwha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] height_value;
    logic [11:0] height_index;

    modport source (output valid, height_value, height_index, input ready);
    modport sink   (input valid, height_value, height_index, output ready);
endinterface

// File: rtl/core/ring_wave_height_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring wave height accumulator
// Keeps a height map in Q1.15, adds damped ring waves to it and reads texels
// back, clearing each one as it is read.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on i_req: command 0 adds one ring wave to every
// texel of the map and gives no response; command 1 reads one texel, returns
// it on o_rsp together with its index and clears it to zero. A read beyond
// the map returns zero and changes nothing.
// A read request passes the read state and then the hand-over state, which
// waits for a free output register and loads the response into it.
// An apply request walks the map one texel at a time; the 17-step square
// root and the five-term exponential recurrence dominate each texel.
// The next request is taken in the cycle after the previous one finishes.
// After reset the block writes full scale into every one of the 4096
// entries of the map, one entry a cycle, and accepts no request meanwhile.
// The response sits in an output register; if the receiver stalls, the block
// still accepts the next request, and a following read waits until that
// register has been taken.
// ----------------------------------------------------------------------------
module ring_wave_height_accumulator_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    rwha_req_if.sink   i_req,
    rwha_rsp_if.source o_rsp
);
    import rwha_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_state  w_state;

    // The controller owns the handshake and the sequencing of every step.
    rwha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_command (i_req.command),
        .i_out_ready  (o_rsp.ready),
        .i_sts        (w_sts),
        .o_in_ready   (i_req.ready),
        .o_out_valid  (o_rsp.valid),
        .o_cmd        (w_cmd),
        .o_state      (w_state)
    );

    // The datapath holds the map and all arithmetic, and captures the
    // request payload when the controller accepts it.
    rwha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_texel_index    (i_req.texel_index),
        .i_center_u       (i_req.center_u),
        .i_center_v       (i_req.center_v),
        .i_ring_frequency (i_req.ring_frequency),
        .i_decay_rate     (i_req.decay_rate),
        .i_phase_time     (i_req.phase_time),
        .o_sts            (w_sts),
        .o_height_value   (o_rsp.height_value),
        .o_height_index   (o_rsp.height_index)
    );

`ifndef SYNTH
    // Heights are clamped, so no response can exceed full scale.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.height_value <= 16'(FULL_SCALE)))
        else $error("response height above full scale");

    // A new response only follows the read hand-over state.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(w_state) == ST_RD_OUT))
        else $error("response raised outside a read");

    // No request is taken while the map is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_CLR) |-> !(i_req.valid && i_req.ready))
        else $error("request accepted during the clearing sweep");

    // The apply sweep only runs from the first texel after a request.
    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_IDLE && i_req.valid && !i_req.command) |=> (w_state == ST_DU))
        else $error("apply request did not start the sweep");
`endif

endmodule

// File: rtl/core/rwha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring wave controller
// Sequences the clearing sweep, texel reads and the per-texel wave steps.
// ----------------------------------------------------------------------------
module rwha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_command,
    input  logic             i_out_ready,
    input  rwha_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rwha_pkg::t_dp_cmd o_cmd,
    output rwha_pkg::t_state  o_state
);
    import rwha_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [2:0]         r_k, n_k;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.k     = r_k;
        case (r_state)
            ST_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.last_texel) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_in_command ? ST_RD : ST_DU;
                end
            end
            ST_RD: begin
                o_cmd.op = OP_RD;
                n_state  = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_RDOUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_DU: begin
                o_cmd.op = OP_DU;
                n_state  = ST_SQ1;
            end
            ST_SQ1: begin
                o_cmd.op = OP_SQ1;
                n_state  = ST_SQ2;
            end
            ST_SQ2: begin
                o_cmd.op = OP_SQ2;
                n_cnt    = CNT_W'(SQRT_STEPS - 1);
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == '0) n_state = ST_PH;
                else             n_cnt   = r_cnt - 1'b1;
            end
            ST_PH: begin
                o_cmd.op = OP_PH;
                n_state  = ST_X2;
            end
            ST_X2: begin
                o_cmd.op = OP_X2;
                n_state  = ST_IN;
            end
            ST_IN: begin
                o_cmd.op = OP_IN;
                n_state  = ST_PO;
            end
            ST_PO: begin
                o_cmd.op = OP_PO;
                n_state  = ST_MG;
            end
            ST_MG: begin
                o_cmd.op = OP_MG;
                n_state  = ST_S;
            end
            ST_S: begin
                o_cmd.op = OP_S;
                n_state  = ST_SS;
            end
            ST_SS: begin
                o_cmd.op = OP_SS;
                n_state  = ST_S3;
            end
            ST_S3: begin
                o_cmd.op = OP_S3;
                n_k      = 3'(EXP_TERMS);
                n_state  = ST_EM;
            end
            ST_EM: begin
                o_cmd.op = OP_EM;
                n_state  = ST_ED;
            end
            ST_ED: begin
                o_cmd.op = OP_ED;
                if (r_k == 3'd1) begin
                    n_state = ST_AT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = ST_EM;
                end
            end
            ST_AT: begin
                o_cmd.op = OP_AT;
                n_state  = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.op = OP_TERM;
                n_state  = ST_WR;
            end
            ST_WR: begin
                o_cmd.op = OP_WR;
                n_state  = i_sts.last_texel ? ST_IDLE : ST_DU;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

// File: rtl/core/rwha_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring wave datapath
// Height map memory, texel coordinate counters and the fixed-point units
// for distance, ring sine, attenuation and accumulation.
// ----------------------------------------------------------------------------
module rwha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwha_pkg::t_dp_cmd i_cmd,
    input  logic [11:0]       i_texel_index,
    input  logic [15:0]       i_center_u,
    input  logic [15:0]       i_center_v,
    input  logic [15:0]       i_ring_frequency,
    input  logic [15:0]       i_decay_rate,
    input  logic [31:0]       i_phase_time,
    output rwha_pkg::t_dp_sts o_sts,
    output logic [15:0]       o_height_value,
    output logic [11:0]       o_height_index
);
    import rwha_pkg::*;

    logic [15:0] r_mem [MAP_SIZE];
    logic [15:0] r_rdata;

    logic [11:0] r_tindex;
    logic [15:0] r_cu, r_cv, r_freq, r_decay;
    logic [31:0] r_time;

    logic [ADDR_W-1:0] r_idx;
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic [16:0]       r_u, r_v;
    logic [RU_W-1:0]   r_ru;
    logic [RV_W-1:0]   r_rv;

    logic [16:0] r_du, r_dv;
    logic [33:0] r_sq, r_rem, r_res, r_bit;
    logic [15:0] r_p;
    logic [32:0] r_z;
    logic [16:0] r_x2;
    logic [33:0] r_yl;
    logic [15:0] r_inner, r_uu, r_prod, r_term;
    logic [9:0]  r_n;
    logic [16:0] r_poly, r_m, r_s, r_ss, r_w, r_e, r_att;
    logic [15:0] r_out_value;
    logic [11:0] r_out_index;

    logic [ADDR_W-1:0] w_addr;
    logic              w_we, w_re, w_in_map;
    logic [15:0]       w_wdata;
    logic [16:0]       w_u, w_v, w_d, w_rx, w_sum;
    logic [15:0]       w_r16;
    logic [1:0]        w_quad;
    logic [33:0]       w_sq_du, w_sq_dv, w_trial, w_x2p, w_inp, w_pop, w_mgp;
    logic [33:0]       w_ssp, w_s3p, w_tp;
    logic [31:0]       w_diff, w_uup;
    logic [39:0]       w_php;
    logic [32:0]       w_zp, w_emp;
    logic [49:0]       w_yp;
    logic [17:0]       w_mg, w_splus, w_sminus, w_s3sum;
    logic [RU_W-1:0]   w_ru_sum;
    logic [RV_W-1:0]   w_rv_sum;
    logic              w_ru_c, w_rv_c;

    assign w_in_map = (32'(r_tindex) < 32'(MAP_SIZE));
    assign w_u      = {1'b0, r_cu};
    assign w_v      = {1'b0, r_cv};
    assign w_d      = r_res[16:0];

    assign w_sq_du  = 34'(r_du) * 34'(r_du);
    assign w_sq_dv  = 34'(r_dv) * 34'(r_dv);
    assign w_trial  = r_res + r_bit;

    assign w_diff   = 32'(w_d) - r_time;
    assign w_php    = 40'(w_diff[23:0]) * 40'(r_freq);
    assign w_zp     = 33'(w_d) * 33'(r_decay);

    assign w_quad   = r_p[15:14];
    assign w_r16    = {r_p[13:0], 2'b00};
    assign w_rx     = w_quad[0] ? 17'(ONE_Q16) - {1'b0, w_r16} : {1'b0, w_r16};

    assign w_x2p    = 34'(w_rx) * 34'(w_rx);
    assign w_yp     = 50'(r_z) * 50'(LOG2E_Q16);
    assign w_inp    = 34'(r_x2) * 34'(SIN_C);
    assign w_uup    = 32'(r_yl[23:8]) * 32'(LN2_Q16);
    assign w_pop    = 34'(r_x2) * 34'(r_inner);
    assign w_mgp    = 34'(w_rx) * 34'(r_poly);
    assign w_mg     = w_mgp[33:16];
    assign w_splus  = 18'(ONE_Q16) + 18'(r_m);
    assign w_sminus = 18'(ONE_Q16) - 18'(r_m);
    assign w_ssp    = 34'(r_s) * 34'(r_s);
    assign w_s3p    = 34'(r_ss) * 34'(r_s);
    assign w_s3sum  = 18'(w_s3p[32:16]) + 18'(ONE_Q16);
    assign w_emp    = 33'(r_uu) * 33'(r_e);
    assign w_tp     = 34'(r_w) * 34'(r_att);
    assign w_sum    = 17'(r_rdata) + 17'(r_term);

    assign w_ru_sum = r_ru + RU_W'(U_STEP_R);
    assign w_ru_c   = (w_ru_sum >= RU_W'(MAP_WIDTH - 1));
    assign w_rv_sum = r_rv + RV_W'(V_STEP_R);
    assign w_rv_c   = (w_rv_sum >= RV_W'(MAP_HEIGHT - 1));

    // Memory port control: one access per cycle.
    always_comb begin
        w_addr  = r_idx;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = '0;
        case (i_cmd.op)
            OP_CLR: begin
                w_we    = 1'b1;
                w_wdata = 16'(FULL_SCALE);
            end
            OP_RD: begin
                w_addr = ADDR_W'(r_tindex);
                w_re   = w_in_map;
            end
            OP_RDOUT: begin
                w_addr = ADDR_W'(r_tindex);
                w_we   = w_in_map;
            end
            OP_DU: begin
                w_re = 1'b1;
            end
            OP_WR: begin
                w_we    = 1'b1;
                w_wdata = (w_sum > 17'(FULL_SCALE)) ? 16'(FULL_SCALE) : w_sum[15:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.op == OP_CLR || i_cmd.op == OP_WR) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.op == OP_LOAD) begin
            r_idx <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_tindex <= i_texel_index;
                r_cu     <= i_center_u;
                r_cv     <= i_center_v;
                r_freq   <= i_ring_frequency;
                r_decay  <= i_decay_rate;
                r_time   <= i_phase_time;
                r_x      <= '0;
                r_y      <= '0;
                r_u      <= '0;
                r_v      <= '0;
                r_ru     <= RU_W'(U_R0);
                r_rv     <= RV_W'(V_R0);
            end
            OP_RDOUT: begin
                r_out_value <= w_in_map ? r_rdata : '0;
                r_out_index <= r_tindex;
            end
            OP_DU: begin
                r_du <= (r_u >= w_u) ? r_u - w_u : w_u - r_u;
                r_dv <= (r_v >= w_v) ? r_v - w_v : w_v - r_v;
            end
            OP_SQ1: r_sq <= w_sq_du;
            OP_SQ2: begin
                r_rem <= r_sq + w_sq_dv;
                r_res <= '0;
                r_bit <= 34'd1 << 32;
            end
            OP_SQRT: begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_PH: begin
                r_p <= w_php[23:8];
                r_z <= w_zp;
            end
            OP_X2: begin
                r_x2 <= w_x2p[32:16];
                r_yl <= w_yp[49:16];
            end
            OP_IN: begin
                r_inner <= 16'(32'(SIN_B) - 32'(w_inp[33:16]));
                r_n     <= r_yl[33:24];
                r_uu    <= w_uup[31:16];
                r_e     <= 17'(ONE_Q16);
            end
            OP_PO: r_poly <= 17'(32'(SIN_A) - 32'(w_pop[33:16]));
            OP_MG: r_m <= (w_mg > 18'(ONE_Q16)) ? 17'(ONE_Q16) : w_mg[16:0];
            OP_S:  r_s <= w_quad[1] ? w_sminus[17:1] : w_splus[17:1];
            OP_SS: r_ss <= w_ssp[32:16];
            OP_S3: r_w <= w_s3sum[17:1];
            OP_EM: r_prod <= w_emp[31:16];
            OP_ED: r_e <= 17'(ONE_Q16) - 17'(div_k(r_prod, i_cmd.k));
            OP_AT: r_att <= (r_n > 10'd16) ? '0 : r_e >> r_n[4:0];
            OP_TERM: r_term <= w_tp[32:17];
            OP_WR: begin
                if (r_x == X_W'(MAP_WIDTH - 1)) begin
                    r_x  <= '0;
                    r_u  <= '0;
                    r_ru <= RU_W'(U_R0);
                    r_y  <= r_y + 1'b1;
                    r_rv <= w_rv_c ? w_rv_sum - RV_W'(MAP_HEIGHT - 1) : w_rv_sum;
                    r_v  <= r_v + 17'(V_STEP_Q) + 17'(w_rv_c);
                end else begin
                    r_x  <= r_x + 1'b1;
                    r_ru <= w_ru_c ? w_ru_sum - RU_W'(MAP_WIDTH - 1) : w_ru_sum;
                    r_u  <= r_u + 17'(U_STEP_Q) + 17'(w_ru_c);
                end
            end
            default: begin
                r_tindex <= r_tindex;
            end
        endcase
    end

    assign o_sts.last_texel = (r_idx == ADDR_W'(MAP_SIZE - 1));
    assign o_height_value   = r_out_value;
    assign o_height_index   = r_out_index;

endmodule
